/* rtl/core/mmm_pkg.sv */
package mmm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int CMD_W     = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = CMD_W + COEF_W;
  localparam int TERM_W    = CMD_W + 2;
  localparam int SUM_W     = 20;
  localparam int REV_W     = SUM_W + 1;
  localparam int DRIVE_W   = 15;
  localparam int IDX_W     = 3;
  localparam int FRAME_W   = 2;
  localparam int MASK_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [DRIVE_W-1:0] ONE = DRIVE_W'(1 << FRAC_BITS);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSED_MASK = 2'd1;

  localparam logic [FRAME_W-1:0] FRAME_VEC8   = 2'd0;
  localparam logic [FRAME_W-1:0] FRAME_QUAD_X = 2'd1;
  localparam logic [FRAME_W-1:0] FRAME_HEXA   = 2'd2;
  localparam logic [FRAME_W-1:0] FRAME_OCTO   = 2'd3;

  typedef logic signed [COEF_W-1:0] coef_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    logic             last;
    logic             rev;
  } ctl_t;

  function automatic logic [IDX_W-1:0] last_index(input logic [FRAME_W-1:0] frame);
    logic [IDX_W-1:0] r;
    r = 3'd7;
    unique case (frame)
      FRAME_VEC8:   r = 3'd7;
      FRAME_QUAD_X: r = 3'd3;
      FRAME_HEXA:   r = 3'd5;
      FRAME_OCTO:   r = 3'd7;
      default:      r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic coef_t coef_cos(input logic [FRAME_W-1:0] frame,
                                     input logic [IDX_W-1:0] idx);
    int r;
    r = 0;
    unique case (frame)
      FRAME_VEC8: begin
        case (idx)
          3'd0: r = 16384;
          3'd1: r = 11585;
          3'd2: r = 0;
          3'd3: r = -11585;
          3'd4: r = -16384;
          3'd5: r = -11585;
          3'd6: r = 0;
          default: r = 11585;
        endcase
      end
      FRAME_QUAD_X: begin
        case (idx)
          3'd0: r = 11585;
          3'd1: r = -11585;
          3'd2: r = -11585;
          3'd3: r = 11585;
          default: r = 0;
        endcase
      end
      FRAME_HEXA: begin
        case (idx)
          3'd0: r = 16384;
          3'd1: r = 8192;
          3'd2: r = -8192;
          3'd3: r = -16384;
          3'd4: r = -8192;
          3'd5: r = 8192;
          default: r = 0;
        endcase
      end
      default: begin
        case (idx)
          3'd0: r = 15137;
          3'd1: r = 6270;
          3'd2: r = -6270;
          3'd3: r = -15137;
          3'd4: r = -15137;
          3'd5: r = -6270;
          3'd6: r = 6270;
          default: r = 15137;
        endcase
      end
    endcase
    return coef_t'(r);
  endfunction

  function automatic coef_t coef_sin(input logic [FRAME_W-1:0] frame,
                                     input logic [IDX_W-1:0] idx);
    int r;
    r = 0;
    unique case (frame)
      FRAME_VEC8: begin
        case (idx)
          3'd0: r = 0;
          3'd1: r = 11585;
          3'd2: r = 16384;
          3'd3: r = 11585;
          3'd4: r = 0;
          3'd5: r = -11585;
          3'd6: r = -16384;
          default: r = -11585;
        endcase
      end
      FRAME_QUAD_X: begin
        case (idx)
          3'd0: r = 11585;
          3'd1: r = 11585;
          3'd2: r = -11585;
          3'd3: r = -11585;
          default: r = 0;
        endcase
      end
      FRAME_HEXA: begin
        case (idx)
          3'd0: r = 0;
          3'd1: r = 14189;
          3'd2: r = 14189;
          3'd3: r = 0;
          3'd4: r = -14189;
          3'd5: r = -14189;
          default: r = 0;
        endcase
      end
      default: begin
        case (idx)
          3'd0: r = 6270;
          3'd1: r = 15137;
          3'd2: r = 15137;
          3'd3: r = 6270;
          3'd4: r = -6270;
          3'd5: r = -15137;
          3'd6: r = -15137;
          default: r = -6270;
        endcase
      end
    endcase
    return coef_t'(r);
  endfunction

endpackage

/* rtl/core/multirotor_motor_mixer.sv */
// Multirotor motor mixer.
// Input channel (in_valid / in_stall): one attitude command per transfer,
// roll, pitch, yaw and throttle in signed Q1.14.
// Output channel (out_valid / out_stall): one transfer per motor of the
// selected frame, motor 0 first, with last set on the final motor.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 frame type,
// index 1 reverse mask; other indexes are ignored. Write only when idle.
// A command is held in an issue register that steps one motor per cycle,
// unless out_stall holds the pipe, into a three-stage pipe: multiply, floor
// and sum, reverse and saturate. A drive passes the issue register, then
// s1, s2 and the output register. A command gives 4, 6 or 8 drives (the
// frame's motor count), set by the single issue counter; the next command
// is taken in the cycle its last motor issues.
// When out_stall is high with a result waiting, the whole pipe holds and
// in_stall rises once the issue register is busy; nothing is lost.
// Reset clears all valid bits and sets frame type and reverse mask to 0.
module multirotor_motor_mixer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [mmm_pkg::CMD_W-1:0]      roll_cmd,
  input  logic signed [mmm_pkg::CMD_W-1:0]      pitch_cmd,
  input  logic signed [mmm_pkg::CMD_W-1:0]      yaw_cmd,
  input  logic signed [mmm_pkg::CMD_W-1:0]      throttle_cmd,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [mmm_pkg::IDX_W-1:0]             motor_index,
  output logic [mmm_pkg::DRIVE_W-1:0]           motor_drive,
  output logic                                  last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mmm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mmm_pkg::MASK_W-1:0]            cfg_data
);

  logic [mmm_pkg::FRAME_W-1:0] frame_sel;
  logic [mmm_pkg::MASK_W-1:0]  reversed_mask;

  logic                               cmd_valid;
  logic [mmm_pkg::IDX_W-1:0]          cmd_idx;
  logic signed [mmm_pkg::CMD_W-1:0]   cmd_roll;
  logic signed [mmm_pkg::CMD_W-1:0]   cmd_pitch;
  logic signed [mmm_pkg::CMD_W-1:0]   cmd_yaw;
  logic signed [mmm_pkg::CMD_W-1:0]   cmd_thr;

  mmm_pkg::ctl_t                      s1_ctl;
  logic signed [mmm_pkg::PROD_W-1:0]  s1_pc;
  logic signed [mmm_pkg::PROD_W-1:0]  s1_ps;
  logic signed [mmm_pkg::TERM_W-1:0]  s1_term;

  mmm_pkg::ctl_t                      s2_ctl;
  logic signed [mmm_pkg::SUM_W-1:0]   s2_sum;

  mmm_pkg::ctl_t                      out_ctl;
  logic [mmm_pkg::DRIVE_W-1:0]        out_drive;

  logic                               pipe_en;
  logic                               issue_last;
  logic                               in_fire;
  mmm_pkg::ctl_t                      s1_ctl_next;
  logic signed [mmm_pkg::TERM_W-1:0]  s1_term_next;
  logic signed [mmm_pkg::SUM_W-1:0]   s2_sum_next;
  logic signed [mmm_pkg::REV_W-1:0]   rev_val;
  logic [mmm_pkg::DRIVE_W-1:0]        out_drive_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_sel     <= '0;
      reversed_mask <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mmm_pkg::REG_FRAME_SEL:     frame_sel     <= cfg_data[mmm_pkg::FRAME_W-1:0];
        mmm_pkg::REG_REVERSED_MASK: reversed_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pipe_en    = !(out_ctl.valid && out_stall);
  assign issue_last = (cmd_idx == mmm_pkg::last_index(frame_sel));
  assign in_stall   = cmd_valid && !(pipe_en && issue_last);
  assign in_fire    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      cmd_idx   <= '0;
    end else if (in_fire) begin
      cmd_valid <= 1'b1;
      cmd_idx   <= '0;
    end else if (cmd_valid && pipe_en) begin
      cmd_valid <= !issue_last;
      cmd_idx   <= cmd_idx + mmm_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_roll  <= roll_cmd;
      cmd_pitch <= pitch_cmd;
      cmd_yaw   <= yaw_cmd;
      cmd_thr   <= throttle_cmd;
    end
  end

  always_comb begin
    s1_ctl_next.valid = cmd_valid;
    s1_ctl_next.idx   = cmd_idx;
    s1_ctl_next.last  = issue_last;
    s1_ctl_next.rev   = reversed_mask[cmd_idx];
    if (cmd_idx[0]) begin
      s1_term_next = mmm_pkg::TERM_W'(cmd_thr) - mmm_pkg::TERM_W'(cmd_yaw);
    end else begin
      s1_term_next = mmm_pkg::TERM_W'(cmd_thr) + mmm_pkg::TERM_W'(cmd_yaw);
    end
  end

  // s2_sum bounds: |terms| stay below 2^17, so SUM_W never wraps
  assign s2_sum_next = mmm_pkg::SUM_W'(s1_term)
                     + mmm_pkg::SUM_W'($signed(s1_pc[mmm_pkg::PROD_W-1:mmm_pkg::FRAC_BITS]))
                     + mmm_pkg::SUM_W'($signed(s1_ps[mmm_pkg::PROD_W-1:mmm_pkg::FRAC_BITS]));

  always_comb begin
    if (s2_ctl.rev) begin
      rev_val = $signed(mmm_pkg::REV_W'(mmm_pkg::ONE)) - mmm_pkg::REV_W'(s2_sum);
    end else begin
      rev_val = mmm_pkg::REV_W'(s2_sum);
    end
    if (rev_val < 0) begin
      out_drive_next = '0;
    end else if (rev_val > $signed(mmm_pkg::REV_W'(mmm_pkg::ONE))) begin
      out_drive_next = mmm_pkg::ONE;
    end else begin
      out_drive_next = rev_val[mmm_pkg::DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl  <= '0;
      s2_ctl  <= '0;
      out_ctl <= '0;
    end else if (pipe_en) begin
      s1_ctl  <= s1_ctl_next;
      s2_ctl  <= s1_ctl;
      out_ctl <= s2_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_pc     <= mmm_pkg::PROD_W'(cmd_roll)
                 * mmm_pkg::PROD_W'(mmm_pkg::coef_cos(frame_sel, cmd_idx));
      s1_ps     <= mmm_pkg::PROD_W'(cmd_pitch)
                 * mmm_pkg::PROD_W'(mmm_pkg::coef_sin(frame_sel, cmd_idx));
      s1_term   <= s1_term_next;
      s2_sum    <= s2_sum_next;
      out_drive <= out_drive_next;
    end
  end

  assign out_valid   = out_ctl.valid;
  assign motor_index = out_ctl.idx;
  assign last        = out_ctl.last;
  assign motor_drive = out_drive;

endmodule
